>>> design/imufp_pkg.sv
package imufp_pkg;

    // Defaults and fixed widths
    localparam int TIME_WIDTH_DEF = 40;
    localparam int BYTE_W         = 8;
    localparam int SAMPLE_W       = 16;
    localparam int INTERVAL_W     = 50;
    localparam int POS_W          = 5;
    localparam int APB_ADDR_W     = 2;
    localparam int APB_DATA_W     = 32;

    // Header decoding
    localparam logic [7:0] HDR_EMPTY         = 8'h80;
    localparam logic [1:0] MODE_CONTROL      = 2'd1;
    localparam logic [1:0] MODE_REGULAR      = 2'd2;
    localparam logic [3:0] PARM_MASK         = 4'h0f;
    localparam logic [3:0] CTRL_INPUT_CONFIG = 4'd2;

    // Payload layout
    localparam logic [POS_W-1:0] TRIPLE_BYTES    = 5'd6;
    localparam logic [POS_W-1:0] CONFIG_LAST_POS = 5'd3;

    // Cross-axis factor is in units of 1/512
    localparam int COMP_SHIFT = 9;
    localparam int NS_PER_US  = 1000;

    // Register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_CROSS_AXIS = 2'd0;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_REGULAR = 2'd1,
        PH_CONFIG  = 2'd2
    } imufp_phase_t;

    // Declared MSB first, so gyro_x lands in the lowest bits when packed.
    typedef struct packed {
        logic [INTERVAL_W-1:0]      interval_ns;
        logic                       accel_fresh;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_x;
    } imufp_result_t;

    // Payload length of a regular frame: mag, gyro and accel each add six bytes.
    function automatic logic [POS_W-1:0] frame_len(input logic [2:0] content);
        logic [POS_W-1:0] len;
        len = '0;
        if (content[2]) len = len + TRIPLE_BYTES;
        if (content[1]) len = len + TRIPLE_BYTES;
        if (content[0]) len = len + TRIPLE_BYTES;
        return len;
    endfunction

endpackage

>>> design/imufp_result.sv
module imufp_result #(
    parameter int TIME_WIDTH = imufp_pkg::TIME_WIDTH_DEF
) (
    input  logic [7:0]                   cross_axis_factor,
    input  logic signed [15:0]           gyro_raw_x,
    input  logic signed [15:0]           gyro_raw_y,
    input  logic signed [15:0]           gyro_raw_z,
    input  logic signed [15:0]           accel_x,
    input  logic signed [15:0]           accel_y,
    input  logic signed [15:0]           accel_z,
    input  logic                         accel_fresh,
    input  logic [TIME_WIDTH-1:0]        now_us,
    input  logic [TIME_WIDTH-1:0]        last_us,
    output imufp_pkg::imufp_result_t     result
);
    import imufp_pkg::*;

    localparam int PROD_W = SAMPLE_W + BYTE_W + 1;

    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] quot;
    logic [TIME_WIDTH-1:0]    diff_us;
    logic [INTERVAL_W-1:0]    diff_ext;

    always_comb begin
        prod = $signed({1'b0, cross_axis_factor}) * gyro_raw_z;
        // Adding divisor minus one to a negative product makes the shift
        // round toward zero.
        biased = prod + (prod[PROD_W-1] ? PROD_W'((1 << COMP_SHIFT) - 1) : PROD_W'(0));
        quot   = biased >>> COMP_SHIFT;
    end

    always_comb begin
        diff_us  = now_us - last_us;
        diff_ext = INTERVAL_W'(diff_us);
    end

    always_comb begin
        result.gyro_x      = gyro_raw_x - quot[SAMPLE_W-1:0];
        result.gyro_y      = gyro_raw_y;
        result.gyro_z      = gyro_raw_z;
        result.accel_x     = accel_x;
        result.accel_y     = accel_y;
        result.accel_z     = accel_z;
        result.accel_fresh = accel_fresh;
        // Microseconds to nanoseconds: 1000 = 1024 - 16 - 8.
        result.interval_ns = (diff_ext << 10) - (diff_ext << 4) - (diff_ext << 3);
    end

endmodule

>>> design/imu_fifo_frame_parser.sv
// Header-mode FIFO frame parser for an inertial sensor byte stream.
//
// Input stream (s_): one FIFO byte per transfer, with its microsecond arrival
// time and a bus error flag. Headers select the frame type; magnetometer
// bytes are skipped, gyro and accel triples are collected little-endian.
// Result stream (m_): one transfer per frame that holds gyro data, carrying
// the cross-axis compensated gyro triple, the latest accel triple, a flag
// for accel that arrived since the previous result, and the interval in ns.
// The APB port holds the cross-axis factor at address 0.
//
// Throughput is one byte per cycle while results are taken. A byte goes into
// an input register and is parsed from there straight into the result
// register, so m_tvalid rises once the frame's last byte has been parsed.
// When the receiver stalls, the result register holds; the input register
// still takes one more byte, then ready drops until the result is taken.
// Reset is synchronous, active low: the parser waits for a header, the
// stored samples, accel flag, last gyro time and factor clear to zero.
module imu_fifo_frame_parser #(
    parameter int TIME_WIDTH = imufp_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [imufp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [imufp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [imufp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata, from bit 0 up: fifo_byte, arrival_time_us, zero fill
    input  logic [((TIME_WIDTH+15)/8)*8-1:0]     s_tdata,
    // s_tuser: bus_error
    input  logic                                 s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata, from bit 0 up: gyro_x, gyro_y, gyro_z, accel_x, accel_y,
    // accel_z, interval_ns, zero fill
    output logic [151:0]                         m_tdata,
    // m_tuser: accel_fresh
    output logic                                 m_tuser
);
    import imufp_pkg::*;

    localparam int M_PAY_W  = 6 * SAMPLE_W + INTERVAL_W;
    localparam int M_DATA_W = ((M_PAY_W + 7) / 8) * 8;

    // Configuration
    logic [7:0] factor_reg;
    logic       cfg_write;

    // Input register
    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic [TIME_WIDTH-1:0] in_time_reg;
    logic                  in_err_reg;

    // Parser state
    imufp_phase_t          phase_reg, phase_next;
    logic [2:0]            content_reg, content_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [7:0]            hold_reg, hold_next;
    logic [15:0]           gyro_reg [3];
    logic [15:0]           gyro_next [3];
    logic [15:0]           accel_reg [3];
    logic [15:0]           accel_next [3];
    logic                  pending_reg, pending_next;
    logic [TIME_WIDTH-1:0] last_time_reg;

    // Result register
    logic                  m_valid_reg;
    imufp_result_t         res_reg;
    imufp_result_t         res_calc;

    logic                  advance;
    logic                  proc;
    logic                  emit;
    logic                  fresh_now;

    // Per-byte decode signals
    logic [POS_W-1:0]      mag_len, gyro_len, acc_len, total_len;
    logic [POS_W-1:0]      rel_pos, acc_rel;
    logic [15:0]           word;
    logic [1:0]            hdr_mode;
    logic [3:0]            hdr_parm;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= '0;
        end else if (cfg_write && paddr == ADDR_CROSS_AXIS) begin
            factor_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_CROSS_AXIS) begin
            prdata = APB_DATA_W'(factor_reg);
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata[7:0];
            in_time_reg <= s_tdata[TIME_WIDTH+7:8];
            in_err_reg  <= s_tuser;
        end
    end

    // Parser next state
    always_comb begin
        phase_next   = phase_reg;
        content_next = content_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        gyro_next    = gyro_reg;
        accel_next   = accel_reg;
        pending_next = pending_reg;
        emit         = 1'b0;
        fresh_now    = pending_reg;

        mag_len   = content_reg[2] ? TRIPLE_BYTES : '0;
        gyro_len  = content_reg[1] ? TRIPLE_BYTES : '0;
        acc_len   = content_reg[0] ? TRIPLE_BYTES : '0;
        total_len = frame_len(content_reg);
        rel_pos   = pos_reg - mag_len;
        acc_rel   = rel_pos - gyro_len;
        word      = {in_byte_reg, hold_reg};
        hdr_mode  = in_byte_reg[7:6];
        hdr_parm  = in_byte_reg[5:2] & PARM_MASK;

        if (in_err_reg) begin
            // A failed transfer restarts the payload; a header is just dropped.
            if (phase_reg == PH_REGULAR || phase_reg == PH_CONFIG) begin
                pos_next = '0;
            end
        end else begin
            unique case (phase_reg)
                PH_REGULAR: begin
                    if (pos_reg >= mag_len && pos_reg < total_len) begin
                        if (!rel_pos[0]) begin
                            hold_next = in_byte_reg;
                        end else if (pos_reg < mag_len + gyro_len) begin
                            gyro_next[rel_pos[2:1]] = word;
                        end else begin
                            accel_next[acc_rel[2:1]] = word;
                        end
                    end
                    if (pos_reg + 5'd1 < total_len) begin
                        pos_next = pos_reg + 5'd1;
                    end else begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                        fresh_now  = pending_reg || (acc_len != '0);
                        if (gyro_len != '0) begin
                            emit         = 1'b1;
                            pending_next = 1'b0;
                        end else begin
                            pending_next = fresh_now;
                        end
                    end
                end
                PH_CONFIG: begin
                    if (pos_reg >= CONFIG_LAST_POS) begin
                        phase_next = PH_HEADER;
                        pos_next   = '0;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
                default: begin
                    // Header phase; an unused phase code behaves the same.
                    phase_next = PH_HEADER;
                    if (in_byte_reg != HDR_EMPTY) begin
                        if (hdr_mode == MODE_REGULAR) begin
                            if (hdr_parm[2:0] != 3'd0) begin
                                phase_next   = PH_REGULAR;
                                content_next = hdr_parm[2:0];
                                pos_next     = '0;
                            end
                        end else if (hdr_mode == MODE_CONTROL &&
                                     hdr_parm == CTRL_INPUT_CONFIG) begin
                            phase_next = PH_CONFIG;
                            pos_next   = '0;
                        end
                    end
                end
            endcase
        end
    end

    imufp_result #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_result (
        .cross_axis_factor (factor_reg),
        .gyro_raw_x        (gyro_next[0]),
        .gyro_raw_y        (gyro_next[1]),
        .gyro_raw_z        (gyro_next[2]),
        .accel_x           (accel_next[0]),
        .accel_y           (accel_next[1]),
        .accel_z           (accel_next[2]),
        .accel_fresh       (fresh_now),
        .now_us            (in_time_reg),
        .last_us           (last_time_reg),
        .result            (res_calc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            content_reg   <= '0;
            pos_reg       <= '0;
            hold_reg      <= '0;
            gyro_reg      <= '{default: '0};
            accel_reg     <= '{default: '0};
            pending_reg   <= 1'b0;
            last_time_reg <= '0;
        end else if (proc) begin
            phase_reg   <= phase_next;
            content_reg <= content_next;
            pos_reg     <= pos_next;
            hold_reg    <= hold_next;
            gyro_reg    <= gyro_next;
            accel_reg   <= accel_next;
            pending_reg <= pending_next;
            if (emit) begin
                last_time_reg <= in_time_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            res_reg <= res_calc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.accel_fresh;
    assign m_tdata  = M_DATA_W'({res_reg.interval_ns,
                                 res_reg.accel_z, res_reg.accel_y, res_reg.accel_x,
                                 res_reg.gyro_z, res_reg.gyro_y, res_reg.gyro_x});

    // A config payload never runs past its fourth byte.
    a_config_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CONFIG |-> pos_reg <= CONFIG_LAST_POS)
        else $error("config payload position out of range");

    // A regular payload always has content and stays inside its frame.
    a_regular_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_REGULAR |-> content_reg != 3'd0 && pos_reg < frame_len(content_reg))
        else $error("regular payload position out of range");

    // An emitted result lands in the result register.
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && emit |=> m_valid_reg)
        else $error("result lost");

    // The interval reference moves to the time of the emitting byte.
    a_last_time: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && emit |=> last_time_reg == $past(in_time_reg))
        else $error("last gyro time not updated");

    // Accel freshness is cleared by every gyro result.
    a_pending_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && emit |=> !pending_reg)
        else $error("accel flag not cleared after result");

endmodule

>>> sim/imu_frame_checker.sv
module imu_frame_checker
    import imufp_pkg::*;
#(
    parameter int TW = TIME_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [APB_ADDR_W-1:0]            paddr,
    input  logic [APB_DATA_W-1:0]            pwdata,
    input  logic                             pready,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // s_tdata, from bit 0 up: fifo_byte, arrival_time_us, zero fill
    input  logic [((TW+15)/8)*8-1:0]         s_tdata,
    // s_tuser: bus_error
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata, from bit 0 up: gyro_x, gyro_y, gyro_z, accel_x, accel_y,
    // accel_z, interval_ns, zero fill
    input  logic [151:0]                     m_tdata,
    // m_tuser: accel_fresh
    input  logic                             m_tuser,
    output int                               error_count,
    output int                               samples_pending
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic                       accel_fresh;
        logic [INTERVAL_W-1:0]      interval_ns;
    } imu_sample_t;

    imu_sample_t expected_samples[$];

    // Shadow of the parser state and the cross-axis register.
    logic [7:0]                 cross_factor;
    imufp_phase_t               phase;
    logic [2:0]                 content;
    logic [POS_W-1:0]           pos;
    logic [BYTE_W-1:0]          low_hold;
    logic signed [SAMPLE_W-1:0] gyro_w [3];
    logic signed [SAMPLE_W-1:0] accel_w [3];
    logic                       accel_pend;
    logic [TW-1:0]              last_gyro_us;

    initial begin
        error_count = 0;
        samples_pending = 0;
    end

    task automatic clear_parser();
        cross_factor = '0;
        phase = PH_HEADER;
        content = '0;
        pos = '0;
        low_hold = '0;
        for (int i = 0; i < 3; i++) begin
            gyro_w[i] = '0;
            accel_w[i] = '0;
        end
        accel_pend = 1'b0;
        last_gyro_us = '0;
    endtask

    // Advances the shadow parser by one byte; sets emitted when a gyro frame completes.
    task automatic parse_fifo_byte(input logic [BYTE_W-1:0] b, input logic [TW-1:0] t,
                                   input logic err, output logic emitted,
                                   output imu_sample_t res);
        logic [POS_W-1:0] mag_len, gyro_len, acc_len, total, rel;
        logic [TW-1:0]    dt;
        logic [63:0]      ns;
        int               gz, gx;
        emitted = 1'b0;
        res = '0;
        if (err) begin
            if (phase != PH_HEADER) pos = '0;
        end else begin
            case (phase)
                PH_REGULAR: begin
                    mag_len  = content[2] ? TRIPLE_BYTES : '0;
                    gyro_len = content[1] ? TRIPLE_BYTES : '0;
                    acc_len  = content[0] ? TRIPLE_BYTES : '0;
                    total = mag_len + gyro_len + acc_len;
                    if (pos >= mag_len && pos < total) begin
                        rel = pos - mag_len;
                        if (!rel[0]) begin
                            low_hold = b;
                        end else if (pos < mag_len + gyro_len) begin
                            gyro_w[(rel >> 1) % 3] = {b, low_hold};
                        end else begin
                            accel_w[((rel - gyro_len) >> 1) % 3] = {b, low_hold};
                        end
                    end
                    if (pos + 1 < total) begin
                        pos = pos + 1'b1;
                    end else begin
                        phase = PH_HEADER;
                        pos = '0;
                        if (acc_len != 0) accel_pend = 1'b1;
                        if (gyro_len != 0) begin
                            gz = gyro_w[2];
                            // Signed division truncates toward zero, as the hardware must.
                            gx = gyro_w[0] - (int'(cross_factor) * gz) / (1 << COMP_SHIFT);
                            dt = t - last_gyro_us;
                            ns = 64'(dt) * 64'(NS_PER_US);
                            res.gyro_x = gx[SAMPLE_W-1:0];
                            res.gyro_y = gyro_w[1];
                            res.gyro_z = gyro_w[2];
                            res.accel_x = accel_w[0];
                            res.accel_y = accel_w[1];
                            res.accel_z = accel_w[2];
                            res.accel_fresh = accel_pend;
                            res.interval_ns = ns[INTERVAL_W-1:0];
                            accel_pend = 1'b0;
                            last_gyro_us = t;
                            emitted = 1'b1;
                        end
                    end
                end
                PH_CONFIG: begin
                    if (pos >= CONFIG_LAST_POS) begin
                        phase = PH_HEADER;
                        pos = '0;
                    end else begin
                        pos = pos + 1'b1;
                    end
                end
                default: begin
                    phase = PH_HEADER;
                    if (b != HDR_EMPTY) begin
                        if (b[7:6] == MODE_REGULAR && b[4:2] != 3'd0) begin
                            phase = PH_REGULAR;
                            content = b[4:2];
                            pos = '0;
                        end else if (b[7:6] == MODE_CONTROL
                                     && (b[5:2] & PARM_MASK) == CTRL_INPUT_CONFIG) begin
                            phase = PH_CONFIG;
                            pos = '0;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        imu_sample_t want, got, res;
        logic        emitted;
        if (!aresetn) begin
            clear_parser();
            expected_samples.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_CROSS_AXIS)
                cross_factor = pwdata[7:0];

            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    $error("result transfer with no sample expected");
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    got.gyro_x = m_tdata[0 +: SAMPLE_W];
                    got.gyro_y = m_tdata[16 +: SAMPLE_W];
                    got.gyro_z = m_tdata[32 +: SAMPLE_W];
                    got.accel_x = m_tdata[48 +: SAMPLE_W];
                    got.accel_y = m_tdata[64 +: SAMPLE_W];
                    got.accel_z = m_tdata[80 +: SAMPLE_W];
                    got.interval_ns = m_tdata[96 +: INTERVAL_W];
                    got.accel_fresh = m_tuser;
                    check_field("gyro_x", want.gyro_x, got.gyro_x);
                    check_field("gyro_y", want.gyro_y, got.gyro_y);
                    check_field("gyro_z", want.gyro_z, got.gyro_z);
                    check_field("accel_x", want.accel_x, got.accel_x);
                    check_field("accel_y", want.accel_y, got.accel_y);
                    check_field("accel_z", want.accel_z, got.accel_z);
                    check_field("accel_fresh", want.accel_fresh, got.accel_fresh);
                    check_field("interval_ns", want.interval_ns, got.interval_ns);
                end
            end

            if (s_tvalid && s_tready) begin
                parse_fifo_byte(s_tdata[BYTE_W-1:0], s_tdata[BYTE_W +: TW], s_tuser,
                                emitted, res);
                if (emitted) expected_samples.push_back(res);
            end
        end
        samples_pending = expected_samples.size();
    end

endmodule

>>> sim/tb_top.sv
module tb_top;
    import imufp_pkg::*;

    localparam int S_TDATA_W       = ((TIME_WIDTH_DEF + 15) / 8) * 8;
    localparam int PHASES          = 5;
    localparam int BYTES_PER_PHASE = 170;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int DIRECTED_LEN    = 27;

    localparam logic [1:0] MODE_RSVD_LOW   = 2'd0;
    localparam logic [1:0] MODE_RSVD_HIGH  = 2'd3;
    localparam logic [3:0] CTRL_SKIP       = 4'd0;
    localparam logic [3:0] CTRL_SENSORTIME = 4'd1;
    localparam logic [3:0] CTRL_OTHER      = 4'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [151:0]          m_tdata;
    logic                  m_tuser;

    int                    error_count;
    int                    samples_pending;
    int                    cycle_count = 0;
    int                    frame_bytes_sent = 0;
    int                    ready_run = 0;
    bit                    gap_free = 1'b0;
    logic [TIME_WIDTH_DEF-1:0] now_us = '0;

    imu_fifo_frame_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    imu_frame_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .error_count     (error_count),
        .samples_pending (samples_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: runs of ready and stall, mostly short, sometimes long.
    always @(posedge aclk) begin
        int r;
        if (ready_run == 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_tready <= 1'b1;
                ready_run = $urandom_range(1, 8);
            end else if (r < 90) begin
                m_tready <= 1'b0;
                ready_run = $urandom_range(1, 3);
            end else if (r < 96) begin
                m_tready <= 1'b0;
                ready_run = $urandom_range(10, 40);
            end else begin
                m_tready <= 1'b1;
                ready_run = $urandom_range(50, 200);
            end
        end else begin
            ready_run--;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_free || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 19))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Called right after a rising edge; returns right after the edge of the transfer.
    task automatic push_byte(input logic [7:0] b, input logic err);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({now_us, b});
        s_tuser <= err;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(0, 99) < 3)
            now_us = TIME_WIDTH_DEF'({$urandom, $urandom});
        else
            now_us = now_us + $urandom_range(0, 400);
    endtask

    // A bus error restarts the payload, so the sender starts it over as well.
    task automatic push_payload(input int len);
        int i;
        i = 0;
        while (i < len) begin
            if ($urandom_range(0, 99) < 3) begin
                push_byte(payload_byte(), 1'b1);
                i = 0;
            end else begin
                push_byte(payload_byte(), 1'b0);
                i++;
            end
        end
        frame_bytes_sent += len;
    endtask

    task automatic send_random_frame();
        int         r, len;
        logic [2:0] content;
        logic [3:0] parm;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            content = 3'($urandom_range(1, 7));
            len = int'(TRIPLE_BYTES) * $countones(content);
            // A few frames are cut short to knock the parser out of step.
            if ($urandom_range(0, 99) < 3) len = $urandom_range(0, len - 1);
            push_byte({MODE_REGULAR, 1'($urandom_range(0, 1)), content,
                       2'($urandom_range(0, 3))}, 1'b0);
            frame_bytes_sent++;
            push_payload(len);
        end else if (r < 80) begin
            push_byte({MODE_CONTROL, CTRL_INPUT_CONFIG, 2'($urandom_range(0, 3))}, 1'b0);
            frame_bytes_sent++;
            push_payload(int'(CONFIG_LAST_POS) + 1);
        end else if (r < 88) begin
            parm = 4'($urandom_range(0, 15));
            if (parm == CTRL_INPUT_CONFIG) parm = CTRL_SKIP;
            push_byte({MODE_CONTROL, parm, 2'($urandom_range(0, 3))}, 1'b0);
        end else if (r < 94) begin
            push_byte(HDR_EMPTY, 1'b0);
        end else begin
            push_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (samples_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [8:0] directed_seq [DIRECTED_LEN];
        logic [7:0] factors [PHASES];

        // {bus_error, byte}: ignored headers, control frames, an accel-only
        // frame and a gyro frame with the upper parameter bit set.
        directed_seq = '{
            {1'b0, HDR_EMPTY},
            {1'b0, MODE_RSVD_LOW, 6'h00},
            {1'b0, MODE_RSVD_HIGH, 6'h07},
            {1'b0, MODE_REGULAR, 4'b0000, 2'b11},
            {1'b0, MODE_CONTROL, CTRL_SKIP, 2'b00},
            {1'b0, MODE_CONTROL, CTRL_SENSORTIME, 2'b00},
            {1'b0, MODE_CONTROL, CTRL_OTHER, 2'b11},
            {1'b1, 8'hFF},
            {1'b0, MODE_CONTROL, CTRL_INPUT_CONFIG, 2'b00},
            {1'b0, 8'hA5}, {1'b0, 8'h5A}, {1'b0, 8'hFF}, {1'b0, 8'h00},
            {1'b0, MODE_REGULAR, 4'b0001, 2'b00},
            {1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'hFF}, {1'b0, 8'h7F},
            {1'b0, 8'h01}, {1'b0, 8'h00},
            {1'b0, MODE_REGULAR, 4'b1010, 2'b00},
            {1'b0, 8'hFF}, {1'b0, 8'h7F}, {1'b0, 8'h00}, {1'b0, 8'h80},
            {1'b0, 8'h00}, {1'b0, 8'h80}
        };
        factors = '{8'd255, 8'($urandom_range(2, 254)), 8'd0, 8'd1, 8'($urandom)};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++) begin
            // The last gyro byte arrives at the top of the time range.
            if (i == DIRECTED_LEN - 1) now_us = '1;
            push_byte(directed_seq[i][7:0], directed_seq[i][8]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            apb_write(ADDR_CROSS_AXIS, APB_DATA_W'(factors[ph]));
            gap_free = (ph == 1);
            while (frame_bytes_sent < (ph + 1) * BYTES_PER_PHASE) send_random_frame();
        end
        wait_idle();

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
